### src/ihnm_pkg.sv
package ihnm_pkg;

  // Hash constants of the FNV-style running hash.
  localparam logic [31:0] HASH_INIT  = 32'hA6B9_3095;
  localparam logic [31:0] HASH_PRIME = 32'h0100_0193;

  // Reciprocal of nine for unsigned operands below 2**32 (shift right by 33).
  localparam logic [31:0] DIV9_MAGIC = 32'h38E3_8E39;
  localparam int          DIV9_SHIFT = 33;

  // Longest mangled name: prefix and digits (7), tilde, dot and three extension chars.
  localparam int NAME_MAX = 12;
  localparam int POS_W    = $clog2(NAME_MAX);

  // Character codes.
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_TILDE      = 8'h7E;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_DOLLAR     = 8'h24;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  // Characters allowed in a short name.
  function automatic logic valid_char(input logic [7:0] c);
    valid_char = (c >= CH_ZERO && c <= CH_NINE) ||
                 (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
                 (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                 c == CH_UNDERSCORE || c == CH_DASH ||
                 c == CH_DOLLAR || c == CH_TILDE;
  endfunction

  // Lower case letters become upper case; everything else passes.
  function automatic logic [7:0] upper_char(input logic [7:0] c);
    upper_char = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_OFFSET : c;
  endfunction

  // Base-36 digit value to its character.
  function automatic logic [7:0] digit_char(input logic [5:0] d);
    digit_char = (d < 6'd10) ? CH_ZERO + 8'(d) : CH_UPPER_A + 8'(d) - 8'd10;
  endfunction

endpackage

### src/iso9660_hashed_name_mangler_unit.sv
// Channel  | Direction | Handshake            | Payload
// in_      | input     | in_valid / in_ready  | in_ch, in_has_char, in_is_dir, in_name_end
// out_     | output    | out_valid / out_ready| out_ch, out_last
//
// Input is taken one transaction per cycle while in_ready holds; the hash update is one constant multiply.
// Each name yields 8 to 12 output characters, one per cycle when out_ready and the digits allow.
// The base-36 conversion does one divide-by-36 per cycle, one for each digit, and overlaps the
// prefix; the digits are held back until it has finished.
// in_ready drops only for a name_end transaction while a finished name waits in the hold
// register. Reset is synchronous; the block takes input in the first cycle after it.
module iso9660_hashed_name_mangler_unit #(
  parameter int PREFIX_LEN = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_has_char,
  input  logic       in_is_dir,
  input  logic       in_name_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_ch,
  output logic       out_last
);
  import ihnm_pkg::*;

  localparam int DIGITS = 7 - PREFIX_LEN;
  localparam int NP_W   = $clog2(PREFIX_LEN + 1);
  localparam int CV_W   = $clog2(DIGITS + 1);

  // Accumulator for the name being received.
  logic [31:0]     acc_hash_r, acc_hash_nxt;
  logic [7:0]      acc_pre_r [PREFIX_LEN];
  logic [7:0]      acc_pre_nxt [PREFIX_LEN];
  logic [NP_W-1:0] acc_npos_r, acc_npos_nxt;
  logic            acc_dot_r, acc_dot_nxt;
  logic [NP_W-1:0] acc_dpos_r, acc_dpos_nxt;
  logic [2:0]      acc_ecnt_r, acc_ecnt_nxt;
  logic [7:0]      acc_ext_r [3];
  logic [7:0]      acc_ext_nxt [3];
  logic            acc_clean_r, acc_clean_nxt;

  // Hold register for a finished name.
  logic             snap_valid_r;
  logic [30:0]      snap_hash_r;
  logic [7:0]       snap_pre_r [PREFIX_LEN];
  logic [7:0]       snap_ext_r [3];
  logic [POS_W-1:0] snap_last_r;

  // Emitter.
  logic             em_busy_r;
  logic [POS_W-1:0] em_pos_r;
  logic [POS_W-1:0] em_last_r;
  logic [CV_W-1:0]  em_conv_r;
  logic [30:0]      em_v_r;
  logic [5:0]       em_dig_r [DIGITS];
  logic [7:0]       em_pre_r [PREFIX_LEN];
  logic [7:0]       em_ext_r [3];

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_ch_r;
  logic       out_last_r;

  logic             in_take;
  logic             name_done;
  logic [7:0]       uc;
  logic             vc;
  logic             keep_ext;
  logic [7:0]       pre_masked [PREFIX_LEN];
  logic [POS_W-1:0] last_idx;
  logic             em_char_ok;
  logic             em_adv;
  logic             em_done;
  logic             em_load;
  logic [7:0]       em_char;
  logic [28:0]      div_q;
  logic [63:0]      div_prod;
  logic [5:0]       div_r;

  assign in_ready  = !(in_name_end && snap_valid_r);
  assign in_take   = in_valid && in_ready;
  assign name_done = in_take && in_name_end;
  assign uc        = upper_char(in_ch);
  assign vc        = valid_char(in_ch);

  // Next state of the accumulator for one name byte.
  always_comb begin
    acc_hash_nxt  = acc_hash_r;
    acc_npos_nxt  = acc_npos_r;
    acc_dot_nxt   = acc_dot_r;
    acc_dpos_nxt  = acc_dpos_r;
    acc_ecnt_nxt  = acc_ecnt_r;
    acc_clean_nxt = acc_clean_r;
    acc_pre_nxt   = acc_pre_r;
    acc_ext_nxt   = acc_ext_r;
    if (in_has_char) begin
      acc_hash_nxt = 32'(acc_hash_r * HASH_PRIME) ^ {{24{in_ch[7]}}, in_ch};
      if (in_ch == CH_DOT) begin
        acc_dot_nxt   = 1'b1;
        acc_dpos_nxt  = acc_npos_r;
        acc_ecnt_nxt  = 3'd0;
        acc_clean_nxt = 1'b1;
      end else if (acc_dot_r) begin
        for (int i = 0; i < 3; i++) begin
          if (acc_ecnt_r == 3'(i)) begin
            acc_ext_nxt[i] = uc;
          end
        end
        if (acc_ecnt_r < 3'd4) begin
          acc_ecnt_nxt = acc_ecnt_r + 3'd1;
        end
        if (!vc) begin
          acc_clean_nxt = 1'b0;
        end
      end
      if (acc_npos_r < NP_W'(PREFIX_LEN)) begin
        for (int i = 0; i < PREFIX_LEN; i++) begin
          if (acc_npos_r == NP_W'(i)) begin
            acc_pre_nxt[i] = vc ? uc : CH_UNDERSCORE;
          end
        end
        acc_npos_nxt = acc_npos_r + NP_W'(1);
      end
    end
  end

  // Final short-name decisions for a name that ends with this transaction.
  always_comb begin
    keep_ext = acc_dot_nxt && !in_is_dir && acc_dpos_nxt != '0 &&
               acc_ecnt_nxt >= 3'd1 && acc_ecnt_nxt <= 3'd3 && acc_clean_nxt;
    for (int i = 0; i < PREFIX_LEN; i++) begin
      pre_masked[i] = (keep_ext && NP_W'(i) >= acc_dpos_nxt) ? CH_UNDERSCORE
                                                              : acc_pre_nxt[i];
    end
    last_idx = POS_W'(PREFIX_LEN + DIGITS);
    if (keep_ext) begin
      last_idx = last_idx + POS_W'(acc_ecnt_nxt) + POS_W'(1);
    end
  end

  // Accumulator registers; they return to reset values after each name.
  always_ff @(posedge clk) begin
    if (!rst_n || name_done) begin
      acc_hash_r  <= HASH_INIT;
      acc_npos_r  <= '0;
      acc_dot_r   <= 1'b0;
      acc_dpos_r  <= '0;
      acc_ecnt_r  <= 3'd0;
      acc_clean_r <= 1'b1;
      for (int i = 0; i < PREFIX_LEN; i++) begin
        acc_pre_r[i] <= CH_UNDERSCORE;
      end
      for (int i = 0; i < 3; i++) begin
        acc_ext_r[i] <= 8'd0;
      end
    end else if (in_take) begin
      acc_hash_r  <= acc_hash_nxt;
      acc_npos_r  <= acc_npos_nxt;
      acc_dot_r   <= acc_dot_nxt;
      acc_dpos_r  <= acc_dpos_nxt;
      acc_ecnt_r  <= acc_ecnt_nxt;
      acc_clean_r <= acc_clean_nxt;
      acc_pre_r   <= acc_pre_nxt;
      acc_ext_r   <= acc_ext_nxt;
    end
  end

  // Hold register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (name_done) begin
      snap_valid_r <= 1'b1;
    end else if (em_load) begin
      snap_valid_r <= 1'b0;
    end
  end

  // Hold register payload.
  always_ff @(posedge clk) begin
    if (name_done) begin
      snap_hash_r <= acc_hash_nxt[30:0];
      snap_pre_r  <= pre_masked;
      snap_ext_r  <= acc_ext_nxt;
      snap_last_r <= last_idx;
    end
  end

  // One divide-by-36 step: divide by four, then by nine with a reciprocal multiply.
  assign div_prod = 64'(em_v_r[30:2]) * 64'(DIV9_MAGIC);
  assign div_q    = 29'(div_prod >> DIV9_SHIFT);
  assign div_r    = 6'(em_v_r - (31'({div_q, 5'b0}) + 31'({div_q, 2'b0})));

  // Character at the emitter position; digits wait for the conversion to finish.
  always_comb begin
    em_char = CH_UNDERSCORE;
    for (int i = 0; i < PREFIX_LEN; i++) begin
      if (em_pos_r == POS_W'(i)) begin
        em_char = em_pre_r[i];
      end
    end
    if (em_pos_r == POS_W'(PREFIX_LEN)) begin
      em_char = CH_TILDE;
    end
    for (int i = 0; i < DIGITS; i++) begin
      if (em_pos_r == POS_W'(PREFIX_LEN + 1 + i)) begin
        em_char = digit_char(em_dig_r[i]);
      end
    end
    if (em_pos_r == POS_W'(PREFIX_LEN + DIGITS + 1)) begin
      em_char = CH_DOT;
    end
    for (int i = 0; i < 3; i++) begin
      if (em_pos_r == POS_W'(PREFIX_LEN + DIGITS + 2 + i)) begin
        em_char = em_ext_r[i];
      end
    end
  end

  assign em_char_ok = em_pos_r <= POS_W'(PREFIX_LEN) || em_conv_r == CV_W'(DIGITS);
  assign em_adv     = em_busy_r && em_char_ok && (!out_valid_r || out_ready);
  assign em_done    = em_adv && em_pos_r == em_last_r;
  assign em_load    = snap_valid_r && (!em_busy_r || em_done);

  // Emitter control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_busy_r <= 1'b0;
      em_pos_r  <= '0;
      em_conv_r <= '0;
    end else if (em_load) begin
      em_busy_r <= 1'b1;
      em_pos_r  <= '0;
      em_conv_r <= '0;
    end else begin
      if (em_done) begin
        em_busy_r <= 1'b0;
      end
      if (em_adv) begin
        em_pos_r <= em_pos_r + POS_W'(1);
      end
      if (em_busy_r && em_conv_r != CV_W'(DIGITS)) begin
        em_conv_r <= em_conv_r + CV_W'(1);
      end
    end
  end

  // Emitter payload and the digit shift line (least significant digit enters first).
  always_ff @(posedge clk) begin
    if (em_load) begin
      em_v_r    <= snap_hash_r;
      em_pre_r  <= snap_pre_r;
      em_ext_r  <= snap_ext_r;
      em_last_r <= snap_last_r;
    end else if (em_busy_r && em_conv_r != CV_W'(DIGITS)) begin
      em_v_r      <= 31'(div_q);
      em_dig_r[0] <= div_r;
      for (int i = 1; i < DIGITS; i++) begin
        em_dig_r[i] <= em_dig_r[i-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (em_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em_adv) begin
      out_ch_r   <= em_char;
      out_last_r <= em_pos_r == em_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ch    = out_ch_r;
  assign out_last  = out_last_r;

  // A newly loaded name starts at its first character with no digits converted.
  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    em_load |=> em_busy_r && em_pos_r == '0 && em_conv_r == '0)
    else $error("emitter did not restart on load");

  // A finished name in the hold register is kept until the emitter takes it.
  a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
    snap_valid_r && !em_load |=> snap_valid_r)
    else $error("finished name lost from hold register");

  // Digits leave only after the full conversion.
  a_digit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    em_adv && em_pos_r > POS_W'(PREFIX_LEN) |-> em_conv_r == CV_W'(DIGITS))
    else $error("digit emitted before conversion finished");

  // Every name is at least prefix, tilde and digits long and at most the maximum.
  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    em_busy_r |-> em_last_r >= POS_W'(PREFIX_LEN + DIGITS) &&
                  em_last_r <= POS_W'(NAME_MAX - 1))
    else $error("mangled name length out of range");

endmodule

### test/iso9660_hashed_name_mangler_unit_tb.sv
`default_nettype none

module iso9660_hashed_name_mangler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ihnm_pkg::*;

  localparam int PREFIX = 3;
  localparam int NAME_ITEMS = 170;
  localparam int CALM_ITEMS = 30;

  // One character of a mangled short name as it leaves the block.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } short_char_t;

  // Tracks the mangler state for each name and holds the short-name characters still owed.
  class short_name_scoreboard #(int PFX = 3);
    logic [31:0] hash;
    logic [7:0]  prefix [PFX];
    logic [7:0]  ext [3];
    int unsigned name_pos;
    int unsigned dot_pos;
    int unsigned ext_len;
    bit          dot_seen;
    bit          ext_ok;
    short_char_t owed_chars [$];
    int          mismatches;
    int          names_done;
    int          chars_checked;

    function new();
      mismatches = 0;
      names_done = 0;
      chars_checked = 0;
      clear();
    endfunction

    // Back to the state of a fresh name.
    function void clear();
      hash = HASH_INIT;
      foreach (prefix[i]) prefix[i] = CH_UNDERSCORE;
      foreach (ext[i]) ext[i] = 8'h00;
      name_pos = 0;
      dot_pos = 0;
      ext_len = 0;
      dot_seen = 1'b0;
      ext_ok = 1'b1;
    endfunction

    function bit is_short_char(logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
             (c >= CH_UPPER_A && c <= CH_UPPER_Z) || c == CH_UNDERSCORE ||
             c == CH_DASH || c == CH_DOLLAR || c == CH_TILDE;
    endfunction

    function logic [7:0] to_upper(logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_OFFSET : c;
    endfunction

    // Fold one byte into the hash and the prefix and extension trackers.
    function void absorb(logic [7:0] c);
      logic [31:0] widened;
      widened = {{24{c[7]}}, c};
      hash = (hash * HASH_PRIME) ^ widened;
      if (c == CH_DOT) begin
        dot_seen = 1'b1;
        dot_pos = name_pos;
        ext_len = 0;
        ext_ok = 1'b1;
      end else if (dot_seen) begin
        if (ext_len < 3) ext[ext_len] = to_upper(c);
        if (ext_len < 4) ext_len++;
        if (!is_short_char(c)) ext_ok = 1'b0;
      end
      if (name_pos < PFX) begin
        prefix[name_pos] = is_short_char(c) ? to_upper(c) : CH_UNDERSCORE;
        name_pos++;
      end
    endfunction

    // Record an accepted input transaction; a name end produces the whole short name.
    function void note_input(logic [7:0] c, logic has_c, logic dir, logic fin);
      logic [7:0]  text [$];
      logic [7:0]  digit_buf [7];
      logic [31:0] rest;
      logic [5:0]  d;
      bit          keep_ext;
      int          digits;
      short_char_t item;
      if (has_c) absorb(c);
      if (!fin) return;

      keep_ext = dot_seen && !dir && dot_pos != 0 && ext_len >= 1 && ext_len <= 3 && ext_ok;
      for (int i = 0; i < PFX; i++)
        text.push_back((keep_ext && i >= dot_pos) ? CH_UNDERSCORE : prefix[i]);
      text.push_back(CH_TILDE);

      // Base-36 digits of the hash with the top bit cleared, most significant first.
      digits = 7 - PFX;
      rest = hash & 32'h7FFF_FFFF;
      for (int i = digits - 1; i >= 0; i--) begin
        d = 6'(rest % 36);
        digit_buf[i] = (d < 10) ? CH_ZERO + 8'(d) : CH_UPPER_A + 8'(d - 10);
        rest = rest / 36;
      end
      for (int i = 0; i < digits; i++) text.push_back(digit_buf[i]);

      if (keep_ext) begin
        text.push_back(CH_DOT);
        for (int i = 0; i < ext_len; i++) text.push_back(ext[i]);
      end

      foreach (text[i]) begin
        item.ch = text[i];
        item.last = (i == text.size() - 1);
        owed_chars.push_back(item);
      end
      names_done++;
      clear();
    endfunction

    // Compare one output transaction against the oldest owed character.
    function void check_output(logic [7:0] c, logic last);
      short_char_t want;
      if (owed_chars.size() == 0) begin
        $display("%0t: unexpected output out_ch 0x%02h out_last %0b", $time, c, last);
        mismatches++;
        return;
      end
      want = owed_chars.pop_front();
      chars_checked++;
      if (c !== want.ch) begin
        $display("%0t: out_ch expected 0x%02h, actual 0x%02h", $time, want.ch, c);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: out_last expected %0b, actual %0b", $time, want.last, last);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return owed_chars.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_ch;
  logic       in_has_char;
  logic       in_is_dir;
  logic       in_name_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_ch;
  logic       out_last;

  bit idle_on = 1'b1;
  int items_sent = 0;
  short_name_scoreboard #(PREFIX) sb;

  iso9660_hashed_name_mangler_unit #(.PREFIX_LEN(PREFIX)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_ch      (in_ch),
    .in_has_char(in_has_char),
    .in_is_dir  (in_is_dir),
    .in_name_end(in_name_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_ch     (out_ch),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watch both channels; inputs are noted before outputs are checked at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_ch, in_has_char, in_is_dir, in_name_end);
      if (out_valid && out_ready) sb.check_output(out_ch, out_last);
    end
  end

  // Output back-pressure in random bursts while idling is enabled.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Present one transaction and hold it until the block takes it.
  task automatic send_item(input logic [7:0] c, input logic has_c, input logic dir,
                           input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_has_char <= has_c;
    in_is_dir <= dir;
    in_name_end <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (has_c || fin) items_sent++;
  endtask

  // Send a whole name from a string; an empty string becomes an empty name.
  task automatic send_name(input string s, input bit dir);
    if (s.len() == 0) begin
      send_item(8'h00, 1'b0, dir, 1'b1);
    end else begin
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, dir, i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] pick_name_char();
    case ($urandom_range(0, 3))
      0: return CH_ZERO + 8'($urandom_range(0, 9));
      1: return CH_LOWER_A + 8'($urandom_range(0, 25));
      2: return CH_UPPER_A + 8'($urandom_range(0, 25));
      default: begin
        case ($urandom_range(0, 3))
          0: return CH_UNDERSCORE;
          1: return CH_DASH;
          2: return CH_DOLLAR;
          default: return CH_TILDE;
        endcase
      end
    endcase
  endfunction

  // Mostly base.ext names with random content; the rest is noise with stray dots and bytes.
  task automatic send_random_name();
    logic [7:0] text [$];
    int         n;
    bit         dir;
    bit         bare_end;
    dir = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 2) != 0) begin
      n = $urandom_range(0, 5);
      repeat (n) text.push_back(pick_name_char());
      text.push_back(CH_DOT);
      n = ($urandom_range(0, 7) == 0) ? 4 : $urandom_range(1, 3);
      repeat (n) text.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : pick_name_char());
    end else begin
      n = $urandom_range(0, 8);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: text.push_back(CH_DOT);
          1, 2: text.push_back(8'($urandom_range(0, 255)));
          default: text.push_back(pick_name_char());
        endcase
      end
    end
    bare_end = (text.size() == 0) || ($urandom_range(0, 4) == 0);
    foreach (text[i]) begin
      // Occasionally slip in an empty transaction that the block must ignore.
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'($urandom), 1'b0);
      send_item(text[i], 1'b1, (!bare_end && i == text.size() - 1) ? dir : 1'($urandom),
                !bare_end && i == text.size() - 1);
    end
    if (bare_end) send_item(8'($urandom), 1'b0, dir, 1'b1);
  endtask

  // Overall time limit.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_ch <= 8'h00;
    in_has_char <= 1'b0;
    in_is_dir <= 1'b0;
    in_name_end <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed names: empty name, ignored transaction, kept and dropped extensions.
    send_name("", 1'b0);
    send_item(8'hFF, 1'b0, 1'b1, 1'b0);
    send_name("zA.c", 1'b0);
    send_name(".x", 1'b0);
    send_name("d.t", 1'b1);
    send_name("a.b!", 1'b0);
    send_name("k.wxyz", 1'b0);

    // Zero byte, bytes with the top bit set and 0x7F, ending without a byte.
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b1);

    // Random names, with the last stretch free of any idling.
    while (items_sent < NAME_ITEMS) begin
      if (items_sent >= NAME_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      send_random_name();
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d name transactions forming %0d names; checked %0d short-name characters.",
             items_sent, sb.names_done, sb.chars_checked);
    $display("Mismatches found: %0d.", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
